### hdl/sfc_pkg.sv
package sfc_pkg;

   // Frame layout
   localparam int unsigned POS_W      = 13;
   localparam int unsigned HEADER_LEN = 5;
   localparam int unsigned PLEN_W     = 12;
   localparam int unsigned SUBLEN_W   = 4;

   localparam logic [7:0] END_BYTE   = 8'hF7;
   localparam logic [7:0] CSUM_MASK  = 8'h7F;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_PAYLOAD_LENGTH   = 2'd0,
      CSR_SUBHEADER_LENGTH = 2'd1,
      CSR_CHECKSUM_ENABLE  = 2'd2,
      CSR_FIX_ENABLE       = 2'd3
   } csr_index_type;

   // Fixed header F0 44 03 00 70
   function automatic logic [7:0] header_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0: val = 8'hF0;
         3'd1: val = 8'h44;
         3'd2: val = 8'h03;
         3'd3: val = 8'h00;
         3'd4: val = 8'h70;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

### hdl/sysex_frame_checker.sv
// sysex_frame_checker: checks, and optionally repairs, system-exclusive frames
// one byte per word.
// req channel: tdata carries the message byte, tuser the frame-start flag; a
//   word with tuser set is position 0 of a new frame.
// rsp channel: one word per req word, in order. tdata is the byte passed on
//   (or the expected byte on checked positions when fixing), tlast marks the
//   closing F7 position, tuser carries the mismatch flag and frame_bad.
// csr channel: always ready; index picks payload_length, subheader_length,
//   checksum_enable or fix_enable. Write only while no word is in flight.
// Path: an accepted word goes into the input register, then through the check
//   logic into the result register, which drives rsp. One word per cycle is
//   sustained while the receiver keeps rsp_tready high; the frame state
//   (position, nibble sum, bad flag) is updated as a word moves from the input
//   register into the result register.
// When the receiver stalls, the result register holds and the input register
//   still takes one more word; req_tready then drops until rsp moves.
// Reset (synchronous, active high) empties both registers, clears the frame
//   state and restores the register defaults (payload 0, subheader 2,
//   checksum and fix enabled). Bytes after the closing byte pass unchanged.
module sysex_frame_checker #(
   parameter int unsigned MAX_PAYLOAD = 4094
) (
   input  logic                       clock,
   input  logic                       reset,
   // req
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] data_byte
   input  logic                       req_tuser,   // [0] frame_start
   // rsp
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] out_byte
   output logic                       rsp_tlast,   // frame_end
   output logic [1:0]                 rsp_tuser,   // [0] mismatch, [1] frame_bad
   // csr
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  sfc_pkg::csr_index_type     csr_index,
   input  logic [sfc_pkg::PLEN_W-1:0] csr_data
);
   import sfc_pkg::*;

   // Clamp limit in position width
   localparam logic [POS_W-1:0] MAX_PLEN = POS_W'(MAX_PAYLOAD);

   // config
   logic [PLEN_W-1:0]   plen_ff;
   logic [SUBLEN_W-1:0] sublen_ff;
   logic                csum_en_ff;
   logic                fix_en_ff;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_start_ff;

   // frame state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       high_ff, high_in;
   logic             bad_ff, bad_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_mis_ff, rsp_mis_in;
   logic       rsp_end_ff, rsp_end_in;
   logic       rsp_bad_ff, rsp_bad_in;

   logic req_fire, adv, step;

   // decode
   logic [POS_W-1:0] pos_cur, plen_eff, pay_start, pay_end, end_pos;
   logic [7:0]       sum_cur, expected;
   logic             bad_cur, checked, is_end;

   assign csr_ready  = 1'b1;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || adv;
   assign req_fire   = req_tvalid && req_tready;
   assign step       = s1_valid_ff && adv;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff    <= '0;
         sublen_ff  <= SUBLEN_W'(2);
         csum_en_ff <= 1'b1;
         fix_en_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PAYLOAD_LENGTH:   plen_ff    <= csr_data;
            CSR_SUBHEADER_LENGTH: sublen_ff  <= csr_data[SUBLEN_W-1:0];
            CSR_CHECKSUM_ENABLE:  csum_en_ff <= csr_data[0];
            CSR_FIX_ENABLE:       fix_en_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // frame layout from current registers
   always_comb begin
      plen_eff = ({1'b0, plen_ff} > MAX_PLEN) ? MAX_PLEN : POS_W'(plen_ff);
      pay_start = POS_W'(HEADER_LEN) + POS_W'(sublen_ff);
      pay_end   = pay_start + plen_eff;
      end_pos   = pay_end + POS_W'(csum_en_ff);
   end

   // per-byte check and state update
   always_comb begin
      pos_cur  = s1_start_ff ? '0 : pos_ff;
      sum_cur  = s1_start_ff ? '0 : sum_ff;
      bad_cur  = s1_start_ff ? 1'b0 : bad_ff;
      expected = '0;
      checked  = 1'b0;
      is_end   = 1'b0;
      sum_in   = sum_cur;
      high_in  = high_ff;

      if (pos_cur < POS_W'(HEADER_LEN)) begin
         expected = header_byte(pos_cur[2:0]);
         checked  = 1'b1;
      end else if (pos_cur < pay_start) begin
         // subheader passes unchecked
      end else if (pos_cur < pay_end) begin
         // even offset from payload start is the high nibble
         if ((pos_cur[0] ^ pay_start[0]) == 1'b0) begin
            high_in = s1_byte_ff;
         end else begin
            sum_in = sum_cur + ({high_ff[3:0], 4'h0} | s1_byte_ff);
         end
      end else if (csum_en_ff && (pos_cur == pay_end)) begin
         expected = (8'h00 - sum_cur) & CSUM_MASK;
         checked  = 1'b1;
      end else if (pos_cur == end_pos) begin
         expected = END_BYTE;
         checked  = 1'b1;
         is_end   = 1'b1;
      end

      rsp_mis_in  = checked && (s1_byte_ff != expected);
      rsp_byte_in = (checked && fix_en_ff) ? expected : s1_byte_ff;
      bad_in      = bad_cur | rsp_mis_in;
      rsp_end_in  = is_end;
      rsp_bad_in  = is_end && bad_in;
      // position holds once past the closing byte
      pos_in      = (pos_cur <= end_pos) ? pos_cur + POS_W'(1) : pos_cur;
   end

   always_comb begin
      s1_valid_in = req_fire ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
      rsp_valid_in = step ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         high_ff      <= '0;
         bad_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            pos_ff  <= pos_in;
            sum_ff  <= sum_in;
            high_ff <= high_in;
            bad_ff  <= bad_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff  <= req_tdata;
         s1_start_ff <= req_tuser;
      end
      if (step) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_mis_ff  <= rsp_mis_in;
         rsp_end_ff  <= rsp_end_in;
         rsp_bad_ff  <= rsp_bad_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tuser  = {rsp_bad_ff, rsp_mis_ff};

endmodule

### hdl/sfc_checker.sv
module sfc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [7:0]                 rsp_tdata,
   input logic                       rsp_tlast,
   input logic [1:0]                 rsp_tuser
);
   import sfc_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // reset empties the pipe
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // frame_bad only on the closing byte
   a_bad_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("frame_bad outside closing byte");

   // a clean closing byte is F7
   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && !rsp_tuser[0] |-> rsp_tdata == END_BYTE)
      else $error("closing byte without mismatch is not F7");

   // a wrong closing byte marks the frame bad
   a_end_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp_tuser[0] |-> rsp_tuser[1])
      else $error("closing mismatch without frame_bad");

endmodule

bind sysex_frame_checker sfc_checker u_sfc_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sfc_pkg::*;

   // Payload length ceiling of the instance; longer register values clamp to it
   localparam int unsigned PAYLOAD_CAP = 4094;
   // Fixed header F0 44 03 00 70, first byte in the lowest bits
   localparam logic [39:0] SYSEX_HEADER = 40'h70_00_03_44_F0;

   // Fault selection for generated frames
   localparam logic [2:0] FAULT_NONE   = 3'b000;
   localparam logic [2:0] FAULT_HEADER = 3'b001;
   localparam logic [2:0] FAULT_CSUM   = 3'b010;
   localparam logic [2:0] FAULT_END    = 3'b100;
   localparam logic [2:0] FAULT_ALL    = 3'b111;

   // One result word as the block should emit it
   typedef struct packed {
      logic [7:0] out_byte;
      logic       mismatch;
      logic       frame_end;
      logic       frame_bad;
   } sysex_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = 8'h00;   // [7:0] data_byte
   logic                 req_tuser = 1'b0;    // [0] frame_start
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;           // [7:0] out_byte
   logic                 rsp_tlast;           // frame_end
   logic [1:0]           rsp_tuser;           // [0] mismatch, [1] frame_bad
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_PAYLOAD_LENGTH;
   logic [PLEN_W-1:0]    csr_data = '0;

   // Register shadow, reset values as the block comes out of reset
   logic [11:0] cfg_payload_len   = 12'd0;
   logic [3:0]  cfg_subheader_len = 4'd2;
   logic        cfg_checksum_en   = 1'b1;
   logic        cfg_fix_en        = 1'b1;

   // Frame state of the predictor
   logic [12:0] frame_pos     = '0;
   logic [7:0]  nibble_sum    = '0;
   logic [7:0]  high_nibble   = '0;
   logic        frame_bad_acc = 1'b0;

   sysex_word_type pending_words[$];   // expected result words, oldest first
   logic [7:0]     frame_bytes[$];     // frame under construction

   bit           idle_on = 1'b1;     // random gaps on both sides
   int unsigned  hold_cycles = 0;    // long receiver hold request
   int unsigned  error_count = 0;
   int unsigned  words_sent = 0;
   int unsigned  words_checked = 0;
   int unsigned  frames_started = 0;
   int unsigned  csr_writes = 0;

   sysex_frame_checker #(
      .MAX_PAYLOAD(PAYLOAD_CAP)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Frame predictor: advances the shadow frame state by one accepted byte and
   // returns the word the block must produce for it. Layout is recomputed from
   // the current registers at every byte, as the block does.
   function automatic sysex_word_type step_frame(input logic [7:0] data, input logic start);
      sysex_word_type w;
      int unsigned plen, pay_start, pay_end, end_pos, pos;
      logic [7:0]  want;
      logic        checked, closing;
      if (start) begin
         frame_pos     = '0;
         nibble_sum    = '0;
         frame_bad_acc = 1'b0;
      end
      plen      = (cfg_payload_len > PAYLOAD_CAP) ? PAYLOAD_CAP : cfg_payload_len;
      pay_start = HEADER_LEN + cfg_subheader_len;
      pay_end   = pay_start + plen;
      end_pos   = pay_end + cfg_checksum_en;
      pos       = frame_pos;
      want      = 8'h00;
      checked   = 1'b0;
      closing   = 1'b0;
      w         = '0;
      w.out_byte = data;
      if (pos < HEADER_LEN) begin
         want    = SYSEX_HEADER[8*pos +: 8];
         checked = 1'b1;
      end else if (pos < pay_start) begin
         // subheader passes straight through
      end else if (pos < pay_end) begin
         // nibble pairs: even offset is the high half, odd offset completes it
         if (((pos - pay_start) & 1) == 0)
            high_nibble = data;
         else
            nibble_sum = nibble_sum + ({high_nibble[3:0], 4'h0} | data);
      end else if (cfg_checksum_en && pos == pay_end) begin
         want    = (8'h00 - nibble_sum) & CSUM_MASK;
         checked = 1'b1;
      end else if (pos == end_pos) begin
         want    = END_BYTE;
         checked = 1'b1;
         closing = 1'b1;
      end
      if (checked) begin
         w.mismatch = (data != want);
         if (cfg_fix_en)
            w.out_byte = want;
         frame_bad_acc = frame_bad_acc | w.mismatch;
      end
      if (closing) begin
         w.frame_end = 1'b1;
         w.frame_bad = frame_bad_acc;
      end
      // position parks just past the closing byte
      if (pos <= end_pos)
         frame_pos = frame_pos + 13'd1;
      return w;
   endfunction

   // Offers one word; returns at the edge that accepts it. tvalid stays high so
   // that back-to-back words need no second assignment in one step.
   task automatic send_word(input logic [7:0] data, input logic start);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      pending_words.push_back(step_frame(data, start));
      words_sent++;
      if (start)
         frames_started++;
   endtask

   task automatic send_bytes(input logic first_start);
      for (int i = 0; i < frame_bytes.size(); i++)
         send_word(frame_bytes[i], first_start && i == 0);
   endtask

   // Stop offering and wait until every expected word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PAYLOAD_LENGTH:   cfg_payload_len   = value;
         CSR_SUBHEADER_LENGTH: cfg_subheader_len = value[3:0];
         CSR_CHECKSUM_ENABLE:  cfg_checksum_en   = value[0];
         CSR_FIX_ENABLE:       cfg_fix_en        = value[0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // All four registers, written only once the pipe is empty
   task automatic set_config(input logic [11:0] plen, input logic [11:0] sub,
                             input logic [11:0] csum, input logic [11:0] fix);
      drain();
      csr_write(CSR_PAYLOAD_LENGTH, plen);
      csr_write(CSR_SUBHEADER_LENGTH, sub);
      csr_write(CSR_CHECKSUM_ENABLE, csum);
      csr_write(CSR_FIX_ENABLE, fix);
      csr_valid <= 1'b0;
   endtask

   // Builds a frame for the current registers into frame_bytes; the selected
   // checked parts get corrupted. Payload is mostly true nibbles, sometimes
   // full bytes to exercise the truncation of the joined value.
   task automatic build_frame(input logic [2:0] faults);
      int unsigned plen;
      logic [7:0]  b, hi, sum;
      frame_bytes.delete();
      plen = (cfg_payload_len > PAYLOAD_CAP) ? PAYLOAD_CAP : cfg_payload_len;
      hi   = 8'h00;
      sum  = 8'h00;
      for (int i = 0; i < HEADER_LEN; i++) begin
         b = SYSEX_HEADER[8*i +: 8];
         if ((faults & FAULT_HEADER) != 0 && $urandom_range(0, 1) == 1)
            b = b ^ 8'($urandom_range(1, 255));
         frame_bytes.push_back(b);
      end
      for (int i = 0; i < cfg_subheader_len; i++)
         frame_bytes.push_back(8'($urandom));
      for (int i = 0; i < plen; i++) begin
         b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
         if (i % 2 == 0)
            hi = b;
         else
            sum = sum + ({hi[3:0], 4'h0} | b);
         frame_bytes.push_back(b);
      end
      if (cfg_checksum_en) begin
         b = (8'h00 - sum) & CSUM_MASK;
         if ((faults & FAULT_CSUM) != 0)
            b = b ^ 8'($urandom_range(1, 255));
         frame_bytes.push_back(b);
      end
      b = END_BYTE;
      if ((faults & FAULT_END) != 0)
         b = b ^ 8'($urandom_range(1, 255));
      frame_bytes.push_back(b);
   endtask

   // Result checker: every accepted word against the oldest expectation
   always @(posedge clock) begin : check_words
      sysex_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result word, out_byte %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== want.mismatch) begin
               $error("mismatch: expected %b, got %b", want.mismatch, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tlast !== want.frame_end) begin
               $error("frame_end: expected %b, got %b", want.frame_end, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser[1] !== want.frame_bad) begin
               $error("frame_bad: expected %b, got %b", want.frame_bad, rsp_tuser[1]);
               error_count++;
            end
            words_checked++;
         end
      end
   end

   // Receiver: random stall bursts, plus a long hold when a test asks for one
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Straight out of reset with no frame-start flag: counting must already run
   // from position 0 under the reset register values. One trailing byte after
   // the closing F7 must pass untouched.
   task automatic test_no_start();
      build_frame(FAULT_NONE);
      frame_bytes.push_back(8'hFF);
      send_bytes(1'b0);
   endtask

   // Nearly every checked position wrong, with fix off then on; data extremes
   // 00/FF, full-byte nibbles, an odd payload and a frame without a checksum.
   task automatic test_checked_bytes();
      set_config(12'd2, 12'd0, 12'd1, 12'd0);
      frame_bytes.delete();
      for (int i = 0; i < HEADER_LEN; i++)
         frame_bytes.push_back((i % 2 == 0) ? 8'hFF : 8'h00);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h80);   // wrong checksum
      frame_bytes.push_back(8'h00);   // wrong closing byte
      send_bytes(1'b1);
      set_config(12'd3, 12'd1, 12'd1, 12'd1);
      build_frame(FAULT_ALL);
      send_bytes(1'b1);
      set_config(12'd0, 12'd0, 12'd0, 12'd1);
      build_frame(FAULT_NONE);
      send_bytes(1'b1);
   endtask

   // Layout changes half way through a frame: the rest of the frame follows
   // the new payload length and the dropped checksum.
   task automatic test_midframe_config();
      set_config(12'd4, 12'd2, 12'd1, 12'd1);
      build_frame(FAULT_NONE);
      for (int i = 0; i < 9; i++)
         send_word(frame_bytes[i], i == 0);
      set_config(12'd6, 12'd2, 12'd0, 12'd1);
      for (int i = 0; i < 4; i++)
         send_word(8'($urandom_range(0, 15)), 1'b0);
      send_word(END_BYTE, 1'b0);
   endtask

   // Upper data bits set on the narrow registers must be dropped
   task automatic test_masked_writes();
      set_config(12'h002, 12'hFF1, 12'hFFE, 12'hABD);
      build_frame(FAULT_NONE);
      send_bytes(1'b1);
   endtask

   // Payload register at all ones with the largest subheader. A whole frame
   // would run to thousands of words, so it is cut after a short stretch of
   // payload and the next frame restarts the count.
   task automatic test_payload_all_ones();
      set_config(12'hFFF, 12'd15, 12'd1, 12'd1);
      build_frame(FAULT_NONE);
      while (frame_bytes.size() > 40)
         void'(frame_bytes.pop_back());
      send_bytes(1'b1);
   endtask

   // Receiver holds off long enough for both pipe stages to fill and the
   // input to stall, while frames keep being offered
   task automatic test_backpressure();
      set_config(12'd8, 12'd2, 12'd1, 12'd0);
      hold_cycles = 300;
      for (int f = 0; f < 3; f++) begin
         build_frame((f == 1) ? FAULT_ALL : FAULT_NONE);
         send_bytes(1'b1);
      end
   endtask

   // Mostly well-formed frames with random content under changing registers;
   // the rest are faulty, start-less, truncated or followed by stray words
   task automatic test_random_frames(input int unsigned word_budget);
      int unsigned first, kind, plen, cut;
      first = words_sent;
      while (words_sent - first < word_budget) begin
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 9))
               0:       plen = $urandom_range(0, 7) * 2 + 1;
               1:       plen = $urandom_range(9, 32) * 2;
               default: plen = $urandom_range(0, 8) * 2;
            endcase
            set_config(12'(plen), 12'($urandom_range(0, 15)),
                       12'($urandom_range(0, 1)), 12'($urandom_range(0, 1)));
         end
         idle_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 9);
         build_frame((kind == 6) ? 3'($urandom_range(1, 7)) : FAULT_NONE);
         if (kind == 8) begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > cut)
               void'(frame_bytes.pop_back());
         end
         send_bytes(kind != 7);
         if (kind == 9) begin
            repeat ($urandom_range(1, 4))
               send_word(8'($urandom), $urandom_range(0, 3) == 0);
         end
      end
      idle_on = 1'b1;
   endtask

   // Closing stretch at full rate, no gaps on either side
   task automatic test_steady_stream(input int unsigned word_budget);
      int unsigned first;
      set_config(12'd6, 12'd2, 12'd1, 12'd1);
      idle_on = 1'b0;
      first = words_sent;
      while (words_sent - first < word_budget) begin
         build_frame(($urandom_range(0, 3) == 0) ? FAULT_ALL : FAULT_NONE);
         send_bytes(1'b1);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_start();
      test_checked_bytes();
      test_midframe_config();
      test_masked_writes();
      test_payload_all_ones();
      test_backpressure();
      test_random_frames(800);
      test_steady_stream(150);
      drain();
      repeat (10) @(posedge clock);
      $display("Covered %0d frames, %0d words checked, %0d register writes,",
               frames_started, words_checked, csr_writes);
      $display("with random gaps and stalls, a long receiver hold and wide registers.");
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog, several times the slowest legal run
   initial begin
      #6ms;
      $display("Timed out with %0d words outstanding", pending_words.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
